[rtl/core/rpm_pkg.sv]
`default_nettype none
package rpm_pkg;

   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_COMPUTE = 2'd1;
   localparam logic [1:0] FUNC_READ    = 2'd2;

   localparam logic [1:0] CSR_GRID_WIDTH      = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT     = 2'd1;
   localparam logic [1:0] CSR_RIDGE_THRESHOLD = 2'd2;

   localparam logic [6:0]  GRID_WIDTH_RESET      = 7'd64;
   localparam logic [6:0]  GRID_HEIGHT_RESET     = 7'd64;
   localparam logic [15:0] RIDGE_THRESHOLD_RESET = 16'd3277;

   // Q1.15 one
   localparam logic [15:0] MASK_ONE = 16'h8000;

   // floor(x / 5) = (x * 52429) >> 18, exact for x below 2^18
   localparam logic [15:0] RECIP5       = 16'd52429;
   localparam int          RECIP5_SHIFT = 18;

   localparam int DIV_STEPS   = 15;
   localparam int GATHER_LAST = 5;

   typedef enum logic [2:0] {
      NB_CENTER = 3'd0,
      NB_XM     = 3'd1,
      NB_XP     = 3'd2,
      NB_YM     = 3'd3,
      NB_YP     = 3'd4
   } nb_type;

   typedef enum logic [1:0] {
      PASS_MM   = 2'd0,
      PASS_RAW  = 2'd1,
      PASS_BLUR = 2'd2
   } pass_type;

   typedef struct packed {
      logic     load_wr;
      logic     blur_rd;
      logic     rsp_load;
      logic     rsp_read;
      logic     mm_init;
      logic     walk_reset;
      logic     walk_step;
      logic     rd_en;
      nb_type   nsel;
      pass_type pass;
      logic     thr_load;
      logic     eval;
      logic     div_step;
      logic     raw_wr;
      logic     blur_wr;
   } cmd_type;

   typedef struct packed {
      logic last_pixel;
      logic need_div;
   } status_type;

endpackage
`default_nettype wire

[rtl/core/rpm_dpath.sv]
`default_nettype none
module rpm_dpath import rpm_pkg::*; #(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output      status_type  status,
   input  wire logic        csr_wr,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   input  wire logic [11:0] req_pixel_index,
   input  wire logic [15:0] req_elevation,
   output      logic [15:0] rsp_mask_value,
   output      logic        rsp_is_read_data
);

   localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(MAX_COLUMNS + 1);
   localparam int YW    = $clog2(MAX_ROWS + 1);
   localparam int PW    = XW + YW;

   logic [6:0]    cfg_width_ff;
   logic [6:0]    cfg_height_ff;
   logic [15:0]   cfg_thr_ff;
   logic [XW-1:0] w_eff;
   logic [YW-1:0] h_eff;
   logic [PW-1:0] n_cells;

   logic [XW-1:0] x_ff;
   logic [YW-1:0] y_ff;
   logic [AW-1:0] row_ff;
   logic          x_last;
   logic          y_last;
   logic [XW-1:0] col_m;
   logic [XW-1:0] col_p;
   logic [AW-1:0] row_m;
   logic [AW-1:0] row_p;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] center_addr;
   logic [AW-1:0] req_addr;
   logic          load_ok;

   logic [15:0] height_mem [DEPTH];
   logic [15:0] raw_mem [DEPTH];
   logic [15:0] blur_mem [DEPTH];
   logic [15:0] height_q_ff;
   logic [15:0] raw_q_ff;
   logic [15:0] blur_q_ff;
   logic        in_range_ff;

   logic        rd_valid_ff;
   nb_type      rd_nsel_ff;
   pass_type    rd_pass_ff;
   logic [15:0] rd_data;

   logic [15:0] lo_ff;
   logic [15:0] hi_ff;
   logic [15:0] center_ff;
   logic [18:0] sum_ff;
   logic [15:0] range_raw;
   logic [15:0] range1;
   logic [31:0] thr_ff;

   logic [17:0] c4;
   logic [17:0] s4;
   logic [17:0] p4;
   logic [31:0] prom;
   logic [32:0] thr2;
   logic [32:0] rem2;
   logic [31:0] rem_ff;
   logic [15:0] mask_ff;
   logic [17:0] sum5;
   logic [33:0] blur_prod;
   logic [15:0] blur_val;

   logic [15:0] rsp_mask_ff;
   logic        rsp_read_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= GRID_WIDTH_RESET;
         cfg_height_ff <= GRID_HEIGHT_RESET;
         cfg_thr_ff    <= RIDGE_THRESHOLD_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_GRID_WIDTH:      cfg_width_ff  <= csr_data[6:0];
            CSR_GRID_HEIGHT:     cfg_height_ff <= csr_data[6:0];
            CSR_RIDGE_THRESHOLD: cfg_thr_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cfg_width_ff == 7'd0) begin
         w_eff = XW'(1);
      end else if (32'(cfg_width_ff) > 32'(MAX_COLUMNS)) begin
         w_eff = XW'(MAX_COLUMNS);
      end else begin
         w_eff = XW'(cfg_width_ff);
      end
      if (cfg_height_ff == 7'd0) begin
         h_eff = YW'(1);
      end else if (32'(cfg_height_ff) > 32'(MAX_ROWS)) begin
         h_eff = YW'(MAX_ROWS);
      end else begin
         h_eff = YW'(cfg_height_ff);
      end
   end

   assign n_cells  = PW'(w_eff) * PW'(h_eff);
   assign req_addr = AW'(req_pixel_index);
   assign load_ok  = 32'(req_pixel_index) < 32'(DEPTH);

   // raster walk over the grid in use
   assign x_last = (x_ff == w_eff - XW'(1));
   assign y_last = (y_ff == h_eff - YW'(1));
   assign status.last_pixel = x_last && y_last;

   always_ff @(posedge clock) begin
      if (cmd.walk_reset) begin
         x_ff   <= '0;
         y_ff   <= '0;
         row_ff <= '0;
      end else if (cmd.walk_step) begin
         if (x_last) begin
            x_ff   <= '0;
            y_ff   <= y_ff + YW'(1);
            row_ff <= row_ff + AW'(w_eff);
         end else begin
            x_ff <= x_ff + XW'(1);
         end
      end
   end

   // clamp neighbors at the grid edge
   assign col_m = (x_ff == '0) ? x_ff : x_ff - XW'(1);
   assign col_p = x_last ? x_ff : x_ff + XW'(1);
   assign row_m = (y_ff == '0) ? row_ff : row_ff - AW'(w_eff);
   assign row_p = y_last ? row_ff : row_ff + AW'(w_eff);
   assign center_addr = row_ff + AW'(x_ff);

   always_comb begin
      case (cmd.nsel)
         NB_CENTER: rd_addr = center_addr;
         NB_XM:     rd_addr = row_ff + AW'(col_m);
         NB_XP:     rd_addr = row_ff + AW'(col_p);
         NB_YM:     rd_addr = row_m + AW'(x_ff);
         NB_YP:     rd_addr = row_p + AW'(x_ff);
         default:   rd_addr = center_addr;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && load_ok) begin
         height_mem[req_addr] <= req_elevation;
      end
      if (cmd.rd_en) begin
         height_q_ff <= height_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.raw_wr) begin
         raw_mem[center_addr] <= mask_ff;
      end
      if (cmd.rd_en) begin
         raw_q_ff <= raw_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.blur_wr) begin
         blur_mem[center_addr] <= blur_val;
      end
      if (cmd.blur_rd) begin
         blur_q_ff   <= blur_mem[req_addr];
         in_range_ff <= 32'(req_pixel_index) < 32'(n_cells);
      end
   end

   // tag the read so the data is booked in the following cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_en;
      end
      rd_nsel_ff <= cmd.nsel;
      rd_pass_ff <= cmd.pass;
   end

   assign rd_data = (rd_pass_ff == PASS_BLUR) ? raw_q_ff : height_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '0;
         hi_ff <= '0;
      end else if (cmd.mm_init) begin
         lo_ff <= 16'hFFFF;
         hi_ff <= '0;
      end else if (rd_valid_ff && rd_pass_ff == PASS_MM) begin
         if (height_q_ff < lo_ff) begin
            lo_ff <= height_q_ff;
         end
         if (height_q_ff > hi_ff) begin
            hi_ff <= height_q_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff && rd_pass_ff != PASS_MM) begin
         if (rd_nsel_ff == NB_CENTER) begin
            center_ff <= rd_data;
            sum_ff    <= (rd_pass_ff == PASS_BLUR) ? 19'(rd_data) : '0;
         end else begin
            sum_ff <= sum_ff + 19'(rd_data);
         end
      end
   end

   assign range_raw = hi_ff - lo_ff;
   assign range1    = (range_raw == '0) ? 16'd1 : range_raw;

   always_ff @(posedge clock) begin
      if (cmd.thr_load) begin
         thr_ff <= {16'd0, cfg_thr_ff} * {16'd0, range1};
      end
   end

   assign c4   = {center_ff, 2'b00};
   assign s4   = sum_ff[17:0];
   assign p4   = (c4 > s4) ? c4 - s4 : '0;
   assign prom = {p4, 14'd0};
   assign thr2 = {thr_ff, 1'b0};
   assign status.need_div = (thr_ff != '0) && (prom > thr_ff) && ({1'b0, prom} < thr2);
   assign rem2 = {rem_ff, 1'b0};

   // restoring divide, one quotient bit per step
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         rem_ff <= prom - thr_ff;
         if (thr_ff == '0) begin
            mask_ff <= (prom != '0) ? MASK_ONE : '0;
         end else if (prom <= thr_ff) begin
            mask_ff <= '0;
         end else if ({1'b0, prom} >= thr2) begin
            mask_ff <= MASK_ONE;
         end else begin
            mask_ff <= '0;
         end
      end else if (cmd.div_step) begin
         if (rem2 >= {1'b0, thr_ff}) begin
            rem_ff  <= 32'(rem2 - {1'b0, thr_ff});
            mask_ff <= {mask_ff[14:0], 1'b1};
         end else begin
            rem_ff  <= rem2[31:0];
            mask_ff <= {mask_ff[14:0], 1'b0};
         end
      end
   end

   // rounded divide by five of the five-point sum
   assign sum5      = 18'(sum_ff + 19'd2);
   assign blur_prod = 34'(sum5) * 34'(RECIP5);
   assign blur_val  = 16'(blur_prod >> RECIP5_SHIFT);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_mask_ff <= (cmd.rsp_read && in_range_ff) ? blur_q_ff : '0;
         rsp_read_ff <= cmd.rsp_read;
      end
   end

   assign rsp_mask_value   = rsp_mask_ff;
   assign rsp_is_read_data = rsp_read_ff;

endmodule
`default_nettype wire

[rtl/core/rpm_ctrl.sv]
`default_nettype none
module rpm_ctrl import rpm_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_func,
   output      logic       req_stall,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output      cmd_type    cmd
);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b00000000001,
      ST_READ     = 11'b00000000010,
      ST_MM_ISSUE = 11'b00000000100,
      ST_MM_ACC   = 11'b00000001000,
      ST_THR      = 11'b00000010000,
      ST_GATHER   = 11'b00000100000,
      ST_EVAL     = 11'b00001000000,
      ST_DIV      = 11'b00010000000,
      ST_RWRITE   = 11'b00100000000,
      ST_BWRITE   = 11'b01000000000,
      ST_DONE     = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] k_ff, k_in;
   logic [3:0] div_cnt_ff, div_cnt_in;
   pass_type   pass_ff, pass_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_set;
   logic       rsp_free;
   logic       accept;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && rsp_free);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.pass   = pass_ff;
      state_in   = state_ff;
      k_in       = k_ff;
      div_cnt_in = div_cnt_ff;
      pass_in    = pass_ff;
      rsp_set    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_LOAD: begin
                     cmd.load_wr  = 1'b1;
                     cmd.rsp_load = 1'b1;
                     rsp_set      = 1'b1;
                  end
                  FUNC_COMPUTE: begin
                     cmd.mm_init    = 1'b1;
                     cmd.walk_reset = 1'b1;
                     state_in       = ST_MM_ISSUE;
                  end
                  FUNC_READ: begin
                     cmd.blur_rd = 1'b1;
                     state_in    = ST_READ;
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                     rsp_set      = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_read = 1'b1;
               rsp_set      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_MM_ISSUE: begin
            cmd.rd_en = 1'b1;
            cmd.nsel  = NB_CENTER;
            cmd.pass  = PASS_MM;
            state_in  = ST_MM_ACC;
         end
         ST_MM_ACC: begin
            if (status.last_pixel) begin
               state_in = ST_THR;
            end else begin
               cmd.walk_step = 1'b1;
               state_in      = ST_MM_ISSUE;
            end
         end
         ST_THR: begin
            cmd.thr_load   = 1'b1;
            cmd.walk_reset = 1'b1;
            pass_in        = PASS_RAW;
            k_in           = '0;
            state_in       = ST_GATHER;
         end
         ST_GATHER: begin
            if (k_ff == 3'(GATHER_LAST)) begin
               k_in     = '0;
               state_in = (pass_ff == PASS_RAW) ? ST_EVAL : ST_BWRITE;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.nsel  = nb_type'(k_ff);
               k_in      = k_ff + 3'd1;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (status.need_div) begin
               div_cnt_in = 4'(DIV_STEPS - 1);
               state_in   = ST_DIV;
            end else begin
               state_in = ST_RWRITE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == '0) begin
               state_in = ST_RWRITE;
            end else begin
               div_cnt_in = div_cnt_ff - 4'd1;
            end
         end
         ST_RWRITE: begin
            cmd.raw_wr = 1'b1;
            if (status.last_pixel) begin
               cmd.walk_reset = 1'b1;
               pass_in        = PASS_BLUR;
            end else begin
               cmd.walk_step = 1'b1;
            end
            state_in = ST_GATHER;
         end
         ST_BWRITE: begin
            cmd.blur_wr = 1'b1;
            if (status.last_pixel) begin
               state_in = ST_DONE;
            end else begin
               cmd.walk_step = 1'b1;
               state_in      = ST_GATHER;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               rsp_set      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_set || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         div_cnt_ff   <= '0;
         pass_ff      <= PASS_MM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         div_cnt_ff   <= div_cnt_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_read_goes_read: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_READ) |=> state_ff == ST_READ)
      else $error("read transaction did not enter the read state");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_IDLE || state_ff == ST_READ
                                    || state_ff == ST_DONE))
      else $error("response raised from an unexpected state");

   a_gather_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GATHER && k_ff == 3'(GATHER_LAST))
      |=> (state_ff == ST_EVAL || state_ff == ST_BWRITE))
      else $error("neighbor gather did not finish into evaluation");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_cnt_ff < 4'(DIV_STEPS))
      else $error("divide step count out of range");

endmodule
`default_nettype wire

[rtl/core/ridge_prominence_mask_core.sv]
`default_nettype none
// Load and unused function codes: result valid in the cycle after the transaction is accepted.
// Read: the mask memory read is registered, then the result register is loaded from it.
// Compute over n = width*height pixels: a min/max scan, the raw mask (neighbor gather on one
// memory port, plus bit-serial divide where needed) and the blur; one transaction in flight
// at a time.
// Reset (synchronous, active high) clears control and configuration; stores start undefined.
module ridge_prominence_mask_core import rpm_pkg::*; #(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [11:0] req_pixel_index,
   input  wire logic [15:0] req_elevation,
   // result channel
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [15:0] rsp_mask_value,
   output      logic        rsp_is_read_data,
   // configuration write channel
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   cmd_type    cmd;
   status_type status;
   logic       csr_wr;

   // the user must write configuration only while idle; the block does not enforce it, so always take it
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   // sequence the scan, gather, divide and write steps
   rpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the stores, raster walk, arithmetic and result register
   rpm_dpath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr           (csr_wr),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_pixel_index  (req_pixel_index),
      .req_elevation    (req_elevation),
      .rsp_mask_value   (rsp_mask_value),
      .rsp_is_read_data (rsp_is_read_data)
   );

endmodule
`default_nettype wire

[dv/tb.sv]
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rpm_pkg::*;

   localparam int          GRID_COLS   = 64;
   localparam int          GRID_ROWS   = 64;
   localparam int          STORE_SIZE  = GRID_COLS * GRID_ROWS;
   localparam logic [1:0]  FUNC_UNUSED = 2'd3;
   localparam int          ITEM_TARGET = 1450;
   localparam longint      CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [1:0]  func;
      logic [11:0] pixel_index;
      logic [15:0] elevation;
   } req_item_type;

   typedef struct {
      logic [15:0] mask_value;
      logic        is_read_data;
   } mask_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [11:0] req_pixel_index;
   logic [15:0] req_elevation;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_mask_value;
   logic        rsp_is_read_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   // Stimulus waiting for the driver, and responses the mask predictor still owes.
   req_item_type pending_reqs[$];
   mask_rsp_type expected_masks[$];

   // Shadow of the block: height, raw and blurred stores plus the register file.
   logic [15:0] height_mem [STORE_SIZE];
   logic [15:0] raw_mem    [STORE_SIZE];
   logic [15:0] blur_mem   [STORE_SIZE];
   logic [6:0]  grid_w_reg;
   logic [6:0]  grid_h_reg;
   logic [15:0] tau_reg;

   int          error_count;
   int          items_queued;
   int          num_loads, num_computes, num_reads, num_noise, num_checked;
   longint      cycle_count;

   // Sender burst state and receiver stall pattern.
   int          burst_left;
   int          gap_left;
   int          stall_mode;
   int          stall_mode_left;

   ridge_prominence_mask_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_pixel_index  (req_pixel_index),
      .req_elevation    (req_elevation),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mask_value   (rsp_mask_value),
      .rsp_is_read_data (rsp_is_read_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Out-of-range grid sizes fold to the nearest legal size.
   function automatic int fold_dim(input logic [6:0] v, input int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   // Walk the grid three times: min/max, raw prominence mask, five-point blur.
   function automatic void compute_ridge_mask();
      int     w, h, x, y, xm, xp, ym, yp;
      int     lo, hi, range_v;
      longint thr, s4, c4, prom, m, s;
      w  = fold_dim(grid_w_reg, GRID_COLS);
      h  = fold_dim(grid_h_reg, GRID_ROWS);
      lo = 65535;
      hi = 0;
      for (int i = 0; i < w * h; i++) begin
         if (height_mem[i] < lo) lo = height_mem[i];
         if (height_mem[i] > hi) hi = height_mem[i];
      end
      range_v = hi - lo;
      if (range_v < 1) range_v = 1;
      thr = longint'(tau_reg) * range_v;
      for (y = 0; y < h; y++) begin
         for (x = 0; x < w; x++) begin
            xm   = (x > 0) ? x - 1 : 0;
            xp   = (x + 1 < w) ? x + 1 : w - 1;
            ym   = (y > 0) ? y - 1 : 0;
            yp   = (y + 1 < h) ? y + 1 : h - 1;
            s4   = longint'(height_mem[y*w+xm]) + height_mem[y*w+xp]
                 + height_mem[ym*w+x] + height_mem[yp*w+x];
            c4   = 4 * longint'(height_mem[y*w+x]);
            prom = (c4 > s4) ? (c4 - s4) * 16384 : 0;
            if (thr == 0)           m = (prom > 0) ? MASK_ONE : 0;
            else if (prom <= thr)   m = 0;
            else if (prom >= 2*thr) m = MASK_ONE;
            else                    m = ((prom - thr) * 32768) / thr;
            raw_mem[y*w+x] = m[15:0];
         end
      end
      for (y = 0; y < h; y++) begin
         for (x = 0; x < w; x++) begin
            xm = (x > 0) ? x - 1 : 0;
            xp = (x + 1 < w) ? x + 1 : w - 1;
            ym = (y > 0) ? y - 1 : 0;
            yp = (y + 1 < h) ? y + 1 : h - 1;
            s  = longint'(raw_mem[y*w+x]) + raw_mem[y*w+xm] + raw_mem[y*w+xp]
               + raw_mem[ym*w+x] + raw_mem[yp*w+x];
            blur_mem[y*w+x] = 16'((s + 2) / 5);
         end
      end
   endfunction

   // Apply one accepted transaction to the shadow and queue its response.
   function automatic void predict_mask(input req_item_type it);
      mask_rsp_type r;
      int        n;
      r.mask_value   = '0;
      r.is_read_data = 1'b0;
      case (it.func)
         FUNC_LOAD: begin
            height_mem[it.pixel_index] = it.elevation;
            num_loads++;
         end
         FUNC_COMPUTE: begin
            compute_ridge_mask();
            num_computes++;
         end
         FUNC_READ: begin
            n = fold_dim(grid_w_reg, GRID_COLS) * fold_dim(grid_h_reg, GRID_ROWS);
            r.mask_value   = (it.pixel_index < n) ? blur_mem[it.pixel_index] : '0;
            r.is_read_data = 1'b1;
            num_reads++;
         end
         default: num_noise++;
      endcase
      expected_masks.push_back(r);
   endfunction

   // Driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      req_item_type it;
      if (reset) begin
         req_valid       <= 1'b0;
         req_func        <= FUNC_LOAD;
         req_pixel_index <= '0;
         req_elevation   <= '0;
         burst_left      <= 0;
         gap_left        <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            it.func        = req_func;
            it.pixel_index = req_pixel_index;
            it.elevation   = req_elevation;
            predict_mask(it);
         end
         // Advance only once the current transaction is gone; otherwise hold it.
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               it = pending_reqs.pop_front();
               req_valid       <= 1'b1;
               req_func        <= it.func;
               req_pixel_index <= it.pixel_index;
               req_elevation   <= it.elevation;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted response against the oldest prediction.
   always @(posedge clock) begin
      mask_rsp_type e;
      if (reset) begin
         rsp_stall       <= 1'b0;
         stall_mode      <= 0;
         stall_mode_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_masks.size() == 0) begin
               $display("%0t: unexpected response mask=%0d read=%0b",
                        $realtime, rsp_mask_value, rsp_is_read_data);
               error_count++;
            end else begin
               e = expected_masks.pop_front();
               num_checked++;
               if (rsp_mask_value !== e.mask_value) begin
                  $display("%0t: mask_value expected %0d actual %0d",
                           $realtime, e.mask_value, rsp_mask_value);
                  error_count++;
               end
               if (rsp_is_read_data !== e.is_read_data) begin
                  $display("%0t: is_read_data expected %0b actual %0b",
                           $realtime, e.is_read_data, rsp_is_read_data);
                  error_count++;
               end
            end
         end
         // Stall pattern: free-running, light, or heavy stretches.
         if (stall_mode_left == 0) begin
            stall_mode      <= $urandom_range(0, 2);
            stall_mode_left <= $urandom_range(10, 80);
            rsp_stall       <= 1'b0;
         end else begin
            stall_mode_left <= stall_mode_left - 1;
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 4) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_masks.size());
         $display("ridge_prominence_mask_core regression: fail");
         $finish;
      end
   end

   task automatic queue_req(input logic [1:0] f, input logic [11:0] idx,
                            input logic [15:0] elev);
      req_item_type it;
      it.func        = f;
      it.pixel_index = idx;
      it.elevation   = elev;
      pending_reqs.push_back(it);
      items_queued++;
   endtask

   // Hold until the sender is empty and every response is back, then settle.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_masks.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(negedge clock);
      while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_GRID_WIDTH:      grid_w_reg = data[6:0];
         CSR_GRID_HEIGHT:     grid_h_reg = data[6:0];
         CSR_RIDGE_THRESHOLD: tau_reg    = data;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [6:0] w, input logic [6:0] h, input logic [15:0] tau);
      wait_idle();
      csr_write(CSR_GRID_WIDTH, {9'd0, w});
      csr_write(CSR_GRID_HEIGHT, {9'd0, h});
      csr_write(CSR_RIDGE_THRESHOLD, tau);
   endtask

   function automatic logic [15:0] terrain_sample(input int shape, input int base);
      case (shape)
         0:       return base[15:0];
         1:       return 16'($urandom);
         2:       return 16'(base + $urandom_range(0, 255));
         default: return ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'(base);
      endcase
   endfunction

   // One phase: set the grid, fill every pixel in shuffled order, compute, read back.
   task automatic run_phase(input logic [6:0] w, input logic [6:0] h, input logic [15:0] tau);
      int n, shape, base, tmp, j, nreads;
      int order[$];
      configure(w, h, tau);
      n     = fold_dim(w, GRID_COLS) * fold_dim(h, GRID_ROWS);
      shape = $urandom_range(0, 3);
      base  = $urandom_range(0, 65280);
      order.delete();
      for (int i = 0; i < n; i++) order.push_back(i);
      for (int i = n - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      foreach (order[i]) begin
         queue_req(FUNC_LOAD, 12'(order[i]), terrain_sample(shape, base));
         if ($urandom_range(0, 15) == 0)
            queue_req(FUNC_UNUSED, 12'($urandom), 16'($urandom));
      end
      // Loads beyond the grid in use land in the store but stay outside this compute.
      if (n < STORE_SIZE && $urandom_range(0, 2) == 0)
         queue_req(FUNC_LOAD, 12'($urandom_range(n, STORE_SIZE - 1)), 16'($urandom));
      queue_req(FUNC_COMPUTE, 12'($urandom), 16'($urandom));
      nreads = (n < 20) ? n + 2 : 20;
      for (int i = 0; i < nreads; i++) begin
         if (n < STORE_SIZE && $urandom_range(0, 7) == 0)
            queue_req(FUNC_READ, 12'($urandom_range(n, STORE_SIZE - 1)), 16'($urandom));
         else
            queue_req(FUNC_READ, 12'($urandom_range(0, n - 1)), 16'($urandom));
      end
      // Sometimes touch up a few pixels and recompute with the same settings.
      if ($urandom_range(0, 2) == 0) begin
         for (int i = 0; i < 4; i++)
            queue_req(FUNC_LOAD, 12'($urandom_range(0, n - 1)), 16'($urandom));
         queue_req(FUNC_COMPUTE, '0, '0);
         for (int i = 0; i < 6; i++)
            queue_req(FUNC_READ, 12'($urandom_range(0, n - 1)), '0);
      end
   endtask

   initial begin
      logic [6:0] w, h;
      logic [15:0] tau;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_LOAD;
      req_pixel_index = '0;
      req_elevation   = '0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = CSR_GRID_WIDTH;
      csr_data        = '0;
      grid_w_reg      = GRID_WIDTH_RESET;
      grid_h_reg      = GRID_HEIGHT_RESET;
      tau_reg         = RIDGE_THRESHOLD_RESET;
      error_count     = 0;
      items_queued    = 0;
      cycle_count     = 0;
      num_loads = 0; num_computes = 0; num_reads = 0; num_noise = 0; num_checked = 0;
      foreach (height_mem[i]) begin
         height_mem[i] = '0;
         raw_mem[i]    = '0;
         blur_mem[i]   = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: 3x2 grid with zero threshold, height extremes, unused code,
      // top store index, out-of-grid reads.
      configure(7'd3, 7'd2, 16'd0);
      queue_req(FUNC_LOAD, 12'd0, 16'd0);
      queue_req(FUNC_LOAD, 12'd1, 16'hFFFF);
      queue_req(FUNC_LOAD, 12'd2, 16'd0);
      queue_req(FUNC_LOAD, 12'd3, 16'd1);
      queue_req(FUNC_LOAD, 12'd4, 16'h8000);
      queue_req(FUNC_LOAD, 12'd5, 16'hFFFF);
      queue_req(FUNC_LOAD, 12'hFFF, 16'hFFFF);
      queue_req(FUNC_UNUSED, 12'hFFF, 16'hFFFF);
      queue_req(FUNC_COMPUTE, 12'hFFF, 16'hFFFF);
      for (int i = 0; i < 6; i++) queue_req(FUNC_READ, 12'(i), '0);
      queue_req(FUNC_READ, 12'd6, '0);
      queue_req(FUNC_READ, 12'hFFF, 16'hFFFF);

      // Size and threshold extremes: flat 1x1, full-scale threshold,
      // width 0 folding to 1, heights above the limit folding to 64.
      run_phase(7'd1, 7'd1, 16'd3277);
      run_phase(7'd4, 7'd4, 16'hFFFF);
      run_phase(7'd0, 7'd127, 16'd0);
      run_phase(7'd64, 7'd1, 16'd1);
      run_phase(7'd1, 7'd64, 16'd3277);
      run_phase(7'd100, 7'd0, 16'd40000);

      // Random phases, mostly small grids.
      while (items_queued < ITEM_TARGET) begin
         w = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 10));
         do h = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 10));
         while (fold_dim(w, GRID_COLS) * fold_dim(h, GRID_ROWS) > 128);
         case ($urandom_range(0, 4))
            0:       tau = 16'd0;
            1:       tau = 16'($urandom_range(0, 4096));
            2:       tau = 16'($urandom_range(60000, 65535));
            default: tau = 16'($urandom);
         endcase
         run_phase(w, h, tau);
      end

      wait_idle();
      repeat (40) @(posedge clock);
      $display("covered %0d loads, %0d computes, %0d reads, %0d unused-code items",
               num_loads, num_computes, num_reads, num_noise);
      $display("%0d responses checked, %0d mismatches", num_checked, error_count);
      if (error_count == 0 && expected_masks.size() == 0)
         $display("ridge_prominence_mask_core regression: pass");
      else
         $display("ridge_prominence_mask_core regression: fail");
      $finish;
   end

endmodule
`default_nettype wire
